FILE: rtl/core/tcu_pkg.sv
package tcu_pkg;

  // sizes
  localparam int NV         = 32;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 6;
  localparam int ROW_W      = 2 * NV;
  localparam int DEG_W      = 5;
  localparam int STK_DEPTH  = NV - 1;
  localparam int SP_W       = 5;
  localparam int SDEG_DEPTH = STK_DEPTH * NV;
  localparam int SDEG_AW    = SP_W + IDX_W;
  localparam int SROW_W     = 4 * NV;
  localparam int STK_W      = SROW_W + DEG_W + 2 * IDX_W;

  // entry codes
  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_BLACK = 2'd1;
  localparam logic [1:0] E_RED   = 2'd2;
  localparam logic [1:0] E_DEL   = 2'd3;

  localparam logic [DEG_W-1:0] DEG_MAX = 5'd31;

  // opcodes
  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_WRITE    = 3'd1;
  localparam logic [2:0] OP_CONTRACT = 3'd2;
  localparam logic [2:0] OP_UNDO     = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  // error codes
  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_ORDER   = 3'd1;
  localparam logic [2:0] ERR_DELETED = 3'd2;
  localparam logic [2:0] ERR_STACK   = 3'd3;
  localparam logic [2:0] ERR_RANGE   = 3'd4;

  // config register indexes
  localparam logic REG_VCOUNT = 1'b0;
  localparam logic REG_IWIDTH = 1'b1;

  typedef enum logic [1:0] {RD_NONE, RD_A, RD_B, RD_WALK} rd_sel_t;

  typedef struct packed {
    logic             latch;
    rd_sel_t          rd_sel;
    logic             cap_a;
    logic             cap_b;
    logic             check;
    logic             clear;
    logic             push;
    logic             wr_a;
    logic             wr_b;
    logic             walk_issue;
    logic [IDX_W-1:0] walk_idx;
    logic             fin_a;
    logic             fin_b;
    logic             undo_end;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] err;
  } stat_t;

  function automatic logic [1:0] ent_get(input logic [ROW_W-1:0] row,
                                         input logic [IDX_W-1:0] idx);
    return row[{idx, 1'b0} +: 2];
  endfunction

  function automatic logic [ROW_W-1:0] ent_put(input logic [ROW_W-1:0] row,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [1:0]       val);
    logic [ROW_W-1:0] r;
    r = row;
    r[{idx, 1'b0} +: 2] = val;
    return r;
  endfunction

  function automatic logic [DEG_W-1:0] sat_up(input logic [DEG_W-1:0] d, input logic en);
    return (en && d != DEG_MAX) ? d + 5'd1 : d;
  endfunction

  function automatic logic [DEG_W-1:0] sat_dn(input logic [DEG_W-1:0] d, input logic en);
    return (en && d != '0) ? d - 5'd1 : d;
  endfunction

endpackage

FILE: rtl/core/tcu_datapath.sv
module tcu_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [5:0]                cfg_wdata,
  input  logic [2:0]                in_opcode,
  input  logic [4:0]                in_vertex_a,
  input  logic [4:0]                in_vertex_b,
  input  logic [1:0]                in_edge_value,
  input  tcu_pkg::cmd_t             cmd,
  output tcu_pkg::stat_t            stat,
  output logic [4:0]                out_current_width,
  output logic [4:0]                out_red_degree_a,
  output logic [1:0]                out_entry_value,
  output logic [4:0]                out_merge_depth,
  output logic [2:0]                out_error_code
);

  // configuration registers
  logic [tcu_pkg::CNT_W-1:0] vcount_r;
  logic [4:0]                iwidth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 6'd32;
      iwidth_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tcu_pkg::REG_VCOUNT: vcount_r <= cfg_wdata;
        tcu_pkg::REG_IWIDTH: iwidth_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // latched beat
  logic [2:0]                op_r;
  logic [tcu_pkg::IDX_W-1:0] a_r, b_r;
  logic [1:0]                ev_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_opcode;
      a_r  <= in_vertex_a;
      b_r  <= in_vertex_b;
      ev_r <= in_edge_value;
    end
  end

  logic [tcu_pkg::CNT_W-1:0] live;
  logic a_in, b_in, in_range, is_con;
  assign live     = (vcount_r > tcu_pkg::CNT_W'(tcu_pkg::NV)) ?
                    tcu_pkg::CNT_W'(tcu_pkg::NV) : vcount_r;
  assign a_in     = {1'b0, a_r} < live;
  assign b_in     = {1'b0, b_r} < live;
  assign in_range = a_in && b_in;
  assign is_con   = (op_r == tcu_pkg::OP_CONTRACT);

  // control registers
  logic [4:0]               width_r;
  logic [tcu_pkg::SP_W-1:0] sp_r, sp_m1;
  logic                     proc_vld_r;
  logic [tcu_pkg::IDX_W-1:0] proc_idx_r;
  assign sp_m1 = sp_r - 5'd1;

  // row memory with per-row valid bits
  logic [tcu_pkg::ROW_W-1:0] adj_mem [tcu_pkg::NV];
  logic [tcu_pkg::NV-1:0]    row_vld_r;
  logic [tcu_pkg::ROW_W-1:0] adj_q_r, row_q;
  logic                      adj_qv_r;
  logic [tcu_pkg::DEG_W-1:0] deg_mem [tcu_pkg::NV];
  logic [tcu_pkg::NV-1:0]    deg_vld_r;
  logic [tcu_pkg::DEG_W-1:0] deg_q_r, deg_q;
  logic                      deg_qv_r;

  logic                      rd_en;
  logic [tcu_pkg::IDX_W-1:0] rd_addr;

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = a_r;
    case (cmd.rd_sel)
      tcu_pkg::RD_A:    rd_addr = a_r;
      tcu_pkg::RD_B:    rd_addr = b_r;
      tcu_pkg::RD_WALK: rd_addr = cmd.walk_idx;
      default:          rd_en   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      adj_q_r  <= adj_mem[rd_addr];
      adj_qv_r <= row_vld_r[rd_addr];
      deg_q_r  <= deg_mem[rd_addr];
      deg_qv_r <= deg_vld_r[rd_addr];
    end
  end

  assign row_q = adj_qv_r ? adj_q_r : '0;
  assign deg_q = deg_qv_r ? deg_q_r : '0;

  // undo stack: saved rows of a and b, the pair and the width
  logic [tcu_pkg::STK_W-1:0]  stk_mem [tcu_pkg::STK_DEPTH];
  logic [tcu_pkg::STK_W-1:0]  stk_q_r;
  logic [tcu_pkg::SROW_W-1:0] s_rows, push_rows;
  logic [tcu_pkg::IDX_W-1:0]  s_a, s_b;
  logic [4:0]                 s_w;
  assign {s_w, s_b, s_a, s_rows} = stk_q_r;

  // saved degrees, one word per stack level and vertex
  logic [tcu_pkg::DEG_W-1:0]   sdeg_mem [tcu_pkg::SDEG_DEPTH];
  logic [tcu_pkg::DEG_W-1:0]   sdeg_q_r;
  logic                        sdeg_re, sdeg_we;
  logic [tcu_pkg::SDEG_AW-1:0] sdeg_raddr, sdeg_waddr;

  assign sdeg_re    = cmd.walk_issue && (op_r == tcu_pkg::OP_UNDO);
  assign sdeg_raddr = {sp_m1, cmd.walk_idx};
  assign sdeg_we    = proc_vld_r && is_con;
  assign sdeg_waddr = {sp_r, proc_idx_r};

  always_ff @(posedge clk) begin
    if (sdeg_we) sdeg_mem[sdeg_waddr] <= deg_q;
    if (sdeg_re) sdeg_q_r <= sdeg_mem[sdeg_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) stk_mem[sp_r] <= {width_r, b_r, a_r, push_rows};
    if (cmd.rd_sel == tcu_pkg::RD_A && sp_r != '0) stk_q_r <= stk_mem[sp_m1];
  end

  // captured rows and degree working registers
  logic [tcu_pkg::ROW_W-1:0] row_a_r, row_b_r;
  logic [tcu_pkg::DEG_W-1:0] deg_a_r, deg_b_r;

  // error check
  logic [2:0] err_c, err_r;
  logic       del_a, del_b;
  assign del_a = tcu_pkg::ent_get(row_a_r, a_r) == tcu_pkg::E_DEL;
  assign del_b = tcu_pkg::ent_get(row_b_r, b_r) == tcu_pkg::E_DEL;

  always_comb begin
    err_c = tcu_pkg::ERR_OK;
    case (op_r)
      tcu_pkg::OP_CLEAR: err_c = tcu_pkg::ERR_OK;
      tcu_pkg::OP_WRITE: begin
        if (!in_range || ev_r > tcu_pkg::E_RED) err_c = tcu_pkg::ERR_RANGE;
        else if (a_r == b_r)                    err_c = tcu_pkg::ERR_ORDER;
        else if (del_a || del_b)                err_c = tcu_pkg::ERR_DELETED;
      end
      tcu_pkg::OP_CONTRACT: begin
        if (!in_range)                                   err_c = tcu_pkg::ERR_RANGE;
        else if (a_r >= b_r)                             err_c = tcu_pkg::ERR_ORDER;
        else if (del_a || del_b)                         err_c = tcu_pkg::ERR_DELETED;
        else if (sp_r >= tcu_pkg::SP_W'(tcu_pkg::STK_DEPTH)) err_c = tcu_pkg::ERR_STACK;
      end
      tcu_pkg::OP_UNDO: begin
        if (sp_r == '0) err_c = tcu_pkg::ERR_STACK;
      end
      tcu_pkg::OP_READ: begin
        if (!in_range) err_c = tcu_pkg::ERR_RANGE;
      end
      default: err_c = tcu_pkg::ERR_RANGE;
    endcase
  end

  assign stat.op  = op_r;
  assign stat.err = err_c;

  // edge write values
  logic                      ab_red, ev_red;
  logic [tcu_pkg::DEG_W-1:0] deg_a_w, deg_b_w, deg_b_fin;
  logic [tcu_pkg::ROW_W-1:0] row_a_w, row_b_w;
  assign ab_red  = tcu_pkg::ent_get(row_a_r, b_r) == tcu_pkg::E_RED;
  assign ev_red  = ev_r == tcu_pkg::E_RED;
  assign deg_a_w = tcu_pkg::sat_up(tcu_pkg::sat_dn(deg_a_r, ab_red), ev_red);
  assign deg_b_w = tcu_pkg::sat_up(tcu_pkg::sat_dn(deg_b_r, ab_red), ev_red);
  assign row_a_w = tcu_pkg::ent_put(row_a_r, b_r, ev_r);
  assign row_b_w = tcu_pkg::ent_put(row_b_r, a_r, ev_r);
  assign deg_b_fin = tcu_pkg::sat_dn(deg_b_r, ab_red);

  // contracted rows of a and b, the packed push word, the saved rows
  logic [tcu_pkg::ROW_W-1:0] rowa_new, rowb_new, sa_row, sb_row;

  always_comb begin
    for (int j = 0; j < tcu_pkg::NV; j++) begin
      rowa_new[2*j +: 2] = (tcu_pkg::CNT_W'(j) < live) ? tcu_pkg::E_DEL : row_a_r[2*j +: 2];
      if (tcu_pkg::CNT_W'(j) < live && tcu_pkg::IDX_W'(j) == a_r)
        rowb_new[2*j +: 2] = tcu_pkg::E_DEL;
      else if (tcu_pkg::CNT_W'(j) < live && tcu_pkg::IDX_W'(j) != b_r)
        rowb_new[2*j +: 2] = (row_a_r[2*j +: 2] == row_b_r[2*j +: 2]) ?
                             row_b_r[2*j +: 2] : tcu_pkg::E_RED;
      else
        rowb_new[2*j +: 2] = row_b_r[2*j +: 2];
      push_rows[4*j +: 4] = {row_b_r[2*j +: 2], row_a_r[2*j +: 2]};
      sa_row[2*j +: 2]    = s_rows[4*j +: 2];
      sb_row[2*j +: 2]    = s_rows[4*j+2 +: 2];
    end
  end

  // per-row step of the walk
  logic                      pin, p_a, p_b, other, pup, pdn;
  logic [1:0]                ra_i, rb_i, nv, sa_i, sb_i;
  logic [tcu_pkg::ROW_W-1:0] crow, urow;
  logic [tcu_pkg::DEG_W-1:0] cdeg;

  assign pin   = {1'b0, proc_idx_r} < live;
  assign p_a   = proc_idx_r == a_r;
  assign p_b   = proc_idx_r == b_r;
  assign other = pin && !p_a && !p_b;
  assign ra_i  = tcu_pkg::ent_get(row_a_r, proc_idx_r);
  assign rb_i  = tcu_pkg::ent_get(row_b_r, proc_idx_r);
  assign nv    = (ra_i == rb_i) ? rb_i : tcu_pkg::E_RED;
  assign pup   = (rb_i != tcu_pkg::E_RED) && (nv == tcu_pkg::E_RED);
  assign pdn   = ra_i == tcu_pkg::E_RED;
  assign cdeg  = other ? tcu_pkg::sat_dn(tcu_pkg::sat_up(deg_q, pup), pdn) : deg_q;
  assign crow  = p_a ? rowa_new :
                 p_b ? rowb_new :
                 other ? tcu_pkg::ent_put(tcu_pkg::ent_put(row_q, a_r, tcu_pkg::E_DEL), b_r, nv)
                       : row_q;
  assign sa_i  = s_rows[{proc_idx_r, 2'b00} +: 2];
  assign sb_i  = s_rows[{proc_idx_r, 2'b10} +: 2];
  assign urow  = (proc_idx_r == s_a) ? sa_row :
                 (proc_idx_r == s_b) ? sb_row :
                 tcu_pkg::ent_put(tcu_pkg::ent_put(row_q, s_a, sa_i), s_b, sb_i);

  // write port selection
  logic                      adj_we, deg_we;
  logic [tcu_pkg::IDX_W-1:0] adj_waddr, deg_waddr;
  logic [tcu_pkg::ROW_W-1:0] adj_wdata;
  logic [tcu_pkg::DEG_W-1:0] deg_wdata;

  always_comb begin
    adj_we    = 1'b0;
    deg_we    = 1'b0;
    adj_waddr = a_r;
    deg_waddr = a_r;
    adj_wdata = row_a_w;
    deg_wdata = deg_a_w;
    if (cmd.wr_a) begin
      adj_we = 1'b1;
      deg_we = 1'b1;
    end else if (cmd.wr_b) begin
      adj_we    = 1'b1;
      deg_we    = 1'b1;
      adj_waddr = b_r;
      deg_waddr = b_r;
      adj_wdata = row_b_w;
      deg_wdata = deg_b_w;
    end else if (proc_vld_r) begin
      adj_we    = 1'b1;
      deg_we    = 1'b1;
      adj_waddr = proc_idx_r;
      deg_waddr = proc_idx_r;
      adj_wdata = is_con ? crow : urow;
      deg_wdata = is_con ? cdeg : sdeg_q_r;
    end else if (cmd.fin_a) begin
      deg_we    = 1'b1;
      deg_wdata = deg_a_r;
    end else if (cmd.fin_b) begin
      deg_we    = 1'b1;
      deg_waddr = b_r;
      deg_wdata = deg_b_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      deg_vld_r <= '0;
    end else if (cmd.clear) begin
      row_vld_r <= '0;
      deg_vld_r <= '0;
    end else begin
      if (adj_we) row_vld_r[adj_waddr] <= 1'b1;
      if (deg_we) deg_vld_r[deg_waddr] <= 1'b1;
    end
  end

  // width and stack pointer
  logic [4:0] wa, width_nxt;
  logic [tcu_pkg::SP_W-1:0] sp_nxt;
  assign wa = (deg_a_r > width_r) ? deg_a_r : width_r;

  always_comb begin
    width_nxt = width_r;
    sp_nxt    = sp_r;
    if (cmd.clear) begin
      width_nxt = iwidth_r;
      sp_nxt    = '0;
    end else if (proc_vld_r && is_con && other && cdeg > width_r) begin
      width_nxt = cdeg;
    end else if (cmd.fin_a) begin
      width_nxt = (deg_b_fin > wa) ? deg_b_fin : wa;
      sp_nxt    = sp_r + 5'd1;
    end else if (cmd.undo_end) begin
      width_nxt = s_w;
      sp_nxt    = sp_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= '0;
      sp_r       <= '0;
      proc_vld_r <= 1'b0;
    end else begin
      width_r    <= width_nxt;
      sp_r       <= sp_nxt;
      proc_vld_r <= cmd.walk_issue;
    end
  end

  // captures, degree counters during the walk, result beat
  always_ff @(posedge clk) begin
    proc_idx_r <= cmd.walk_idx;
    if (cmd.cap_a) row_a_r <= row_q;
    if (cmd.cap_b) row_b_r <= row_q;
    if (cmd.check) err_r <= err_c;
    if (cmd.cap_a)
      deg_a_r <= deg_q;
    else if (proc_vld_r && is_con && pin && pdn)
      deg_a_r <= tcu_pkg::sat_dn(deg_a_r, 1'b1);
    if (cmd.cap_b)
      deg_b_r <= deg_q;
    else if (proc_vld_r && is_con && other && pup)
      deg_b_r <= tcu_pkg::sat_up(deg_b_r, 1'b1);
    if (cmd.out_load) begin
      out_current_width <= width_r;
      out_red_degree_a  <= a_in ? deg_q : '0;
      out_entry_value   <= in_range ? tcu_pkg::ent_get(row_q, b_r) : tcu_pkg::E_NONE;
      out_merge_depth   <= sp_r;
      out_error_code    <= err_r;
    end
  end

endmodule

FILE: rtl/core/tcu_ctrl.sv
module tcu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  tcu_pkg::stat_t stat,
  output tcu_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           out_strobe
);

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_CAPB, S_CHK, S_WRA, S_WRB,
    S_WALK, S_DRAIN, S_FINA, S_FINB, S_ORD, S_OUT
  } state_t;

  state_t                    state_r;
  logic [tcu_pkg::IDX_W-1:0] cnt_r;
  logic                      busy_r, strobe_r;
  logic                      ok;

  assign ok         = stat.err == tcu_pkg::ERR_OK;
  assign busy       = busy_r;
  assign out_strobe = strobe_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_RDA;
            busy_r  <= 1'b1;
          end
        end
        S_RDA:  state_r <= S_RDB;
        S_RDB:  state_r <= S_CAPB;
        S_CAPB: state_r <= S_CHK;
        S_CHK: begin
          cnt_r <= '0;
          if (!ok) begin
            state_r <= S_ORD;
          end else begin
            case (stat.op)
              tcu_pkg::OP_WRITE:    state_r <= S_WRA;
              tcu_pkg::OP_CONTRACT: state_r <= S_WALK;
              tcu_pkg::OP_UNDO:     state_r <= S_WALK;
              default:              state_r <= S_ORD;
            endcase
          end
        end
        S_WRA:  state_r <= S_WRB;
        S_WRB:  state_r <= S_ORD;
        S_WALK: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == tcu_pkg::IDX_W'(tcu_pkg::NV - 1)) state_r <= S_DRAIN;
        end
        S_DRAIN: state_r <= (stat.op == tcu_pkg::OP_CONTRACT) ? S_FINA : S_ORD;
        S_FINA:  state_r <= S_FINB;
        S_FINB:  state_r <= S_ORD;
        S_ORD:   state_r <= S_OUT;
        S_OUT: begin
          state_r  <= S_IDLE;
          busy_r   <= 1'b0;
          strobe_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // commands to the datapath
  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = tcu_pkg::RD_NONE;
    cmd.latch      = (state_r == S_IDLE) && start;
    cmd.walk_idx   = cnt_r;
    case (state_r)
      S_RDA:  cmd.rd_sel = tcu_pkg::RD_A;
      S_RDB: begin
        cmd.rd_sel = tcu_pkg::RD_B;
        cmd.cap_a  = 1'b1;
      end
      S_CAPB: cmd.cap_b = 1'b1;
      S_CHK: begin
        cmd.check = 1'b1;
        cmd.clear = ok && (stat.op == tcu_pkg::OP_CLEAR);
        cmd.push  = ok && (stat.op == tcu_pkg::OP_CONTRACT);
      end
      S_WRA:  cmd.wr_a = 1'b1;
      S_WRB:  cmd.wr_b = 1'b1;
      S_WALK: begin
        cmd.rd_sel     = tcu_pkg::RD_WALK;
        cmd.walk_issue = 1'b1;
      end
      S_DRAIN: cmd.undo_end = (stat.op == tcu_pkg::OP_UNDO);
      S_FINA:  cmd.fin_a = 1'b1;
      S_FINB:  cmd.fin_b = 1'b1;
      S_ORD:   cmd.rd_sel = tcu_pkg::RD_A;
      S_OUT:   cmd.out_load = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/trigraph_contraction_with_undo_core.sv
// Trigraph store over 32 vertices with contraction and undo. A command is
// taken when start is high and busy is low; exactly one result follows,
// shown for one cycle with out_strobe, and the receiver cannot stall it.
// Contract and undo walk all 32 rows through the row memory, one row a
// cycle, reading the next row while the previous one is written back.
// Clear works through per-row valid bits, so there is no clearing pass
// after reset. A new command may be started in the cycle the strobe is
// high.
module trigraph_contraction_with_undo_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_opcode,
  input  logic [4:0] in_vertex_a,
  input  logic [4:0] in_vertex_b,
  input  logic [1:0] in_edge_value,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [5:0] cfg_wdata,
  output logic       out_strobe,
  output logic [4:0] out_current_width,
  output logic [4:0] out_red_degree_a,
  output logic [1:0] out_entry_value,
  output logic [4:0] out_merge_depth,
  output logic [2:0] out_error_code
);

  tcu_pkg::cmd_t  cmd;
  tcu_pkg::stat_t stat;

  // sequencer
  tcu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // store, stack and result registers
  tcu_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_opcode         (in_opcode),
    .in_vertex_a       (in_vertex_a),
    .in_vertex_b       (in_vertex_b),
    .in_edge_value     (in_edge_value),
    .cmd               (cmd),
    .stat              (stat),
    .out_current_width (out_current_width),
    .out_red_degree_a  (out_red_degree_a),
    .out_entry_value   (out_entry_value),
    .out_merge_depth   (out_merge_depth),
    .out_error_code    (out_error_code)
  );

endmodule

FILE: rtl/core/tcu_checker.sv
module tcu_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // a result beat never lands while a command is in flight
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result beat while busy");

  // one beat per command
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result beat repeated");

  // finishing a command always delivers its result
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_strobe) else $error("command ended without result");

endmodule

bind trigraph_contraction_with_undo_core tcu_checker u_tcu_checker (.*);
